FILE: rtl/ttss_pkg.sv
// Shared types, codes and constants of the timed transmit start/stop scheduler.
// Used by ttss_ctrl, ttss_dp and timed_tx_start_stop_scheduler; depends on nothing.
`timescale 1ns / 1ps

package ttss_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int CMD_W      = 3;
  localparam int TIME_W     = 63;
  localparam int SUM_W      = TIME_W + 1;
  localparam int WORD_W     = 32;
  localparam int MARGIN_W   = 16;
  localparam int OPC_W      = 8;
  localparam int CODE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [MARGIN_W-1:0] LEAD_MARGIN_RST = 16'd150;
  localparam logic [OPC_W-1:0]    OPCODE_RST      = 8'd0;
  localparam logic [SUM_W-1:0]    WIN_LIMIT       = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_POLL      = 3'd0,
    CMD_START_AT  = 3'd1,
    CMD_STOP_AT   = 3'd2,
    CMD_START_NOW = 3'd3,
    CMD_STOP_NOW  = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_e;

  typedef enum logic [CODE_W-1:0] {
    STS_OK         = 3'd0,
    STS_PAIRING    = 3'd1,
    STS_QUEUE_FULL = 3'd2,
    STS_TOO_LATE   = 3'd3,
    STS_INVALID    = 3'd4
  } status_e;

  typedef enum logic [CODE_W-1:0] {
    ACT_NONE      = 3'd0,
    ACT_ARM_ON    = 3'd1,
    ACT_ARM_OFF   = 3'd2,
    ACT_FORCE_ON  = 3'd3,
    ACT_FORCE_OFF = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAD_MARGIN    = 1'b0,
    REG_MAILBOX_OPCODE = 1'b1
  } cfg_reg_e;

  // Outcome of inspecting the queue head during a poll walk
  typedef enum logic [1:0] {
    EV_WAIT       = 2'd0,
    EV_ARM        = 2'd1,
    EV_LATE_START = 2'd2,
    EV_LATE_STOP  = 2'd3
  } eval_kind_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREP   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_WALK   = 6'b001000,
    S_EVAL   = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] etime;
    logic [WORD_W-1:0] offs;
    logic [WORD_W-1:0] len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_e           status;
    action_e           action;
    logic [WORD_W-1:0] mb_high;
    logic [WORD_W-1:0] mb_low;
    logic [WORD_W-1:0] cmp_time;
  } result_t;

  localparam result_t RES_NONE = '{
    status:   STS_OK,
    action:   ACT_NONE,
    mb_high:  '0,
    mb_low:   '0,
    cmp_time: '0
  };

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic exec;
    logic rd_head;
    logic eval;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             is_poll;
    logic             busy;
    logic             empty;
    logic             out_free;
    logic             pend_valid;
    eval_kind_e       kind;
    logic [CNT_W-1:0] entry_count;
  } dp_sts_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [WORD_W-1:0] mb_high(input logic [OPC_W-1:0] opc,
                                                 input logic on);
    return {opc, {(WORD_W - OPC_W - 1){1'b0}}, on};
  endfunction

endpackage

FILE: rtl/ttss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ttss_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/ttss_ctrl.sv
// Sequencing state machine of the scheduler: input handshake and walk control.
// Depends on ttss_pkg.
`timescale 1ns / 1ps

module ttss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ttss_pkg::dp_sts_t sts,
  output ttss_pkg::dp_cmd_t cmd
);

  ttss_pkg::state_e state_r, state_nxt;
  logic             emit_ok;

  // An emitting step must first move a held result out
  assign emit_ok = !sts.pend_valid || sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ttss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ttss_pkg::S_PREP;
        end
      end
      ttss_pkg::S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ttss_pkg::S_EXEC;
      end
      ttss_pkg::S_EXEC: begin
        if (sts.is_poll) begin
          state_nxt = ttss_pkg::S_WALK;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ttss_pkg::S_IDLE;
        end
      end
      ttss_pkg::S_WALK: begin
        if (!sts.busy && !sts.empty) begin
          cmd.rd_head = 1'b1;
          state_nxt   = ttss_pkg::S_EVAL;
        end else begin
          state_nxt = ttss_pkg::S_FINISH;
        end
      end
      ttss_pkg::S_EVAL: begin
        unique case (sts.kind)
          ttss_pkg::EV_WAIT: begin
            state_nxt = ttss_pkg::S_FINISH;
          end
          ttss_pkg::EV_LATE_START: begin
            cmd.eval  = 1'b1;
            state_nxt = ttss_pkg::S_WALK;
          end
          ttss_pkg::EV_ARM: begin
            if (emit_ok) begin
              cmd.eval  = 1'b1;
              state_nxt = ttss_pkg::S_FINISH;
            end
          end
          ttss_pkg::EV_LATE_STOP: begin
            if (emit_ok) begin
              cmd.eval  = 1'b1;
              state_nxt = ttss_pkg::S_WALK;
            end
          end
          default: state_nxt = ttss_pkg::S_FINISH;
        endcase
      end
      ttss_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ttss_pkg::S_IDLE;
        end
      end
      default: state_nxt = ttss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/ttss_dp.sv
// Datapath of the scheduler: item registers, queue pointers, parity, event RAM,
// pending result and output register. Depends on ttss_pkg and ttss_ram.
`timescale 1ns / 1ps

module ttss_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ttss_pkg::dp_cmd_t                  cmd,
  output ttss_pkg::dp_sts_t                  sts,
  input  logic [ttss_pkg::CMD_W-1:0]         in_cmd,
  input  logic [ttss_pkg::TIME_W-1:0]        in_time_point,
  input  logic [ttss_pkg::WORD_W-1:0]        in_data_offset,
  input  logic [ttss_pkg::WORD_W-1:0]        in_data_length,
  input  logic [ttss_pkg::TIME_W-1:0]        in_now,
  input  logic                               in_comparator_busy,
  input  logic                               cfg_wr,
  input  logic [ttss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttss_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ttss_pkg::result_t                  out_res,
  output logic                               out_last
);

  // Item registers
  logic [ttss_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [ttss_pkg::TIME_W-1:0]   tp_r, tp_nxt;
  logic [ttss_pkg::WORD_W-1:0]   offs_r, offs_nxt;
  logic [ttss_pkg::WORD_W-1:0]   len_r, len_nxt;
  logic [ttss_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic                          busy_r, busy_nxt;
  logic [ttss_pkg::SUM_W-1:0]    ready_r, ready_nxt;
  logic [ttss_pkg::SUM_W-1:0]    win_r, win_nxt;

  // Configuration
  logic [ttss_pkg::MARGIN_W-1:0] lead_margin_r, lead_margin_nxt;
  logic [ttss_pkg::OPC_W-1:0]    opcode_r, opcode_nxt;

  // Queue state
  logic [ttss_pkg::IDX_W-1:0]    head_r, head_nxt;
  logic [ttss_pkg::IDX_W-1:0]    tail_r, tail_nxt;
  logic [ttss_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                          parity_r, parity_nxt;
  logic [ttss_pkg::IDX_W-1:0]    head_p1, head_p2;

  // Result staging
  logic                          pend_valid_r, pend_valid_nxt;
  ttss_pkg::result_t             pend_r, pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ttss_pkg::result_t             out_r, out_nxt;
  logic                          out_last_r, out_last_nxt;

  // Event RAM
  logic                          wr_en;
  ttss_pkg::entry_t              wr_entry;
  logic [ttss_pkg::ENTRY_W-1:0]  rd_data;
  ttss_pkg::entry_t              rd_entry;

  ttss_pkg::eval_kind_e          kind;
  logic                          out_free;
  logic                          is_start;
  logic                          emit;
  ttss_pkg::result_t             res;
  ttss_pkg::result_t             new_res;

  ttss_ram #(
    .WIDTH (ttss_pkg::ENTRY_W),
    .DEPTH (ttss_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_en   (cmd.rd_head),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign rd_entry = ttss_pkg::entry_t'(rd_data);
  assign head_p1  = ttss_pkg::next_slot(head_r);
  assign head_p2  = ttss_pkg::next_slot(head_p1);
  assign out_free = !out_valid_r || out_ready;

  // Classify the head entry against the window and arming bounds
  always_comb begin
    if ({1'b0, rd_entry.etime} > win_r) begin
      kind = ttss_pkg::EV_WAIT;
    end else if (ready_r < {1'b0, rd_entry.etime}) begin
      kind = ttss_pkg::EV_ARM;
    end else if (rd_entry.start) begin
      kind = ttss_pkg::EV_LATE_START;
    end else begin
      kind = ttss_pkg::EV_LATE_STOP;
    end
  end

  assign is_start = (cmd_r == ttss_pkg::CMD_START_AT);

  always_comb begin
    wr_entry = '{start: is_start, etime: tp_r,
                 offs: is_start ? offs_r : '0, len: len_r};
  end

  always_comb begin
    cmd_nxt         = cmd_r;
    tp_nxt          = tp_r;
    offs_nxt        = offs_r;
    len_nxt         = len_r;
    now_nxt         = now_r;
    busy_nxt        = busy_r;
    ready_nxt       = ready_r;
    win_nxt         = win_r;
    lead_margin_nxt = lead_margin_r;
    opcode_nxt      = opcode_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    parity_nxt      = parity_r;
    pend_valid_nxt  = pend_valid_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_nxt         = out_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    res             = ttss_pkg::RES_NONE;
    new_res         = ttss_pkg::RES_NONE;
    emit            = 1'b0;

    if (cmd.capture) begin
      cmd_nxt        = in_cmd;
      tp_nxt         = in_time_point;
      offs_nxt       = in_data_offset;
      len_nxt        = in_data_length;
      now_nxt        = in_now;
      busy_nxt       = in_comparator_busy;
      pend_valid_nxt = 1'b0;
    end

    if (cmd.prep) begin
      ready_nxt = {1'b0, now_r} + ttss_pkg::SUM_W'(lead_margin_r);
      win_nxt   = {1'b0, now_r} + ttss_pkg::WIN_LIMIT;
    end

    if (cmd.exec) begin
      unique case (cmd_r) inside
        ttss_pkg::CMD_START_AT, ttss_pkg::CMD_STOP_AT: begin
          if (parity_r == is_start) begin
            res.status = ttss_pkg::STS_PAIRING;
          end else if (count_r >= ttss_pkg::CNT_W'(ttss_pkg::QUEUE_DEPTH)) begin
            res.status = ttss_pkg::STS_QUEUE_FULL;
          end else begin
            parity_nxt = !parity_r;
            if (is_start && ({1'b0, tp_r} < ready_r)) begin
              // late start still flips parity
              res.status = ttss_pkg::STS_TOO_LATE;
            end else begin
              wr_en     = 1'b1;
              tail_nxt  = ttss_pkg::next_slot(tail_r);
              count_nxt = count_r + ttss_pkg::CNT_W'(1);
            end
          end
        end
        ttss_pkg::CMD_START_NOW: begin
          res.action  = ttss_pkg::ACT_FORCE_ON;
          res.mb_high = ttss_pkg::mb_high(opcode_r, 1'b1);
        end
        ttss_pkg::CMD_STOP_NOW: begin
          res.action  = ttss_pkg::ACT_FORCE_OFF;
          res.mb_high = ttss_pkg::mb_high(opcode_r, 1'b0);
        end
        ttss_pkg::CMD_CLEAR: begin
          head_nxt   = '0;
          tail_nxt   = '0;
          count_nxt  = '0;
          parity_nxt = 1'b0;
        end
        default: begin
          res.status = ttss_pkg::STS_INVALID;
        end
      endcase
      out_nxt       = res;
      out_last_nxt  = 1'b1;
      out_valid_nxt = 1'b1;
    end

    if (cmd.eval) begin
      unique case (kind)
        ttss_pkg::EV_ARM: begin
          emit             = 1'b1;
          new_res.action   = rd_entry.start ? ttss_pkg::ACT_ARM_ON : ttss_pkg::ACT_ARM_OFF;
          new_res.mb_high  = ttss_pkg::mb_high(opcode_r, rd_entry.start);
          new_res.mb_low   = rd_entry.start ? rd_entry.offs : rd_entry.len;
          new_res.cmp_time = rd_entry.etime[ttss_pkg::WORD_W-1:0];
          head_nxt         = head_p1;
          count_nxt        = count_r - ttss_pkg::CNT_W'(1);
        end
        ttss_pkg::EV_LATE_START: begin
          // drop the start and the entry after it
          if (count_r >= ttss_pkg::CNT_W'(2)) begin
            head_nxt  = head_p2;
            count_nxt = count_r - ttss_pkg::CNT_W'(2);
          end else begin
            head_nxt  = head_p1;
            count_nxt = count_r - ttss_pkg::CNT_W'(1);
          end
        end
        ttss_pkg::EV_LATE_STOP: begin
          emit            = 1'b1;
          new_res.action  = ttss_pkg::ACT_FORCE_OFF;
          new_res.mb_high = ttss_pkg::mb_high(opcode_r, 1'b0);
          head_nxt        = head_p1;
          count_nxt       = count_r - ttss_pkg::CNT_W'(1);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (emit) begin
        if (pend_valid_r) begin
          out_nxt       = pend_r;
          out_last_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
        end
        pend_nxt       = new_res;
        pend_valid_nxt = 1'b1;
      end
    end

    if (cmd.finish) begin
      out_nxt        = pend_valid_r ? pend_r : ttss_pkg::RES_NONE;
      out_last_nxt   = 1'b1;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      unique case (cfg_index)
        ttss_pkg::REG_LEAD_MARGIN:    lead_margin_nxt = cfg_data;
        ttss_pkg::REG_MAILBOX_OPCODE: opcode_nxt      = cfg_data[ttss_pkg::OPC_W-1:0];
        default:                      lead_margin_nxt = lead_margin_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_margin_r <= ttss_pkg::LEAD_MARGIN_RST;
      opcode_r      <= ttss_pkg::OPCODE_RST;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      parity_r      <= 1'b0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      lead_margin_r <= lead_margin_nxt;
      opcode_r      <= opcode_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      count_r       <= count_nxt;
      parity_r      <= parity_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tp_r       <= tp_nxt;
    offs_r     <= offs_nxt;
    len_r      <= len_nxt;
    now_r      <= now_nxt;
    busy_r     <= busy_nxt;
    ready_r    <= ready_nxt;
    win_r      <= win_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.is_poll     = (cmd_r == ttss_pkg::CMD_POLL);
  assign sts.busy        = busy_r;
  assign sts.empty       = (count_r == '0);
  assign sts.out_free    = out_free;
  assign sts.pend_valid  = pend_valid_r;
  assign sts.kind        = kind;
  assign sts.entry_count = count_r;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

endmodule

FILE: rtl/timed_tx_start_stop_scheduler.sv
// Top level of the timed transmit start/stop scheduler.
// Depends on ttss_pkg, ttss_ctrl, ttss_dp (which holds ttss_ram).
`timescale 1ns / 1ps

// The scheduler takes one command transfer at a time and answers with one or
// more result transfers, the final one flagged by out_last. Timed starts and
// stops are checked against the start/stop parity and queue fill and, unless
// a start is already too late to arm, stored in a 64-entry event RAM;
// immediate starts and stops answer with a forced level and mailbox word; a
// clear resets the queue pointers and parity. A poll walks the queue head
// while the comparator is idle: each visited entry costs one RAM read and
// one compare step, and the walk stops early at an entry that arms or waits.
// The result side can stall a poll or any other command before its result
// goes out. A finished result sits in the output register while the next
// command is accepted. The event RAM needs no clearing after reset; only
// entries inside the queue are ever read. Configuration writes are always
// ready and must be issued only while no command is in flight.
module timed_tx_start_stop_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ttss_pkg::CMD_W-1:0]        in_cmd,
  input  logic [ttss_pkg::TIME_W-1:0]       in_time_point,
  input  logic [ttss_pkg::WORD_W-1:0]       in_data_offset,
  input  logic [ttss_pkg::WORD_W-1:0]       in_data_length,
  input  logic [ttss_pkg::TIME_W-1:0]       in_now,
  input  logic                              in_comparator_busy,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ttss_pkg::CODE_W-1:0]       out_status,
  output logic [ttss_pkg::CODE_W-1:0]       out_action,
  output logic [ttss_pkg::WORD_W-1:0]       out_mailbox_high,
  output logic [ttss_pkg::WORD_W-1:0]       out_mailbox_low,
  output logic [ttss_pkg::WORD_W-1:0]       out_compare_time,
  output logic                              out_last,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ttss_pkg::dp_cmd_t dp_cmd;
  ttss_pkg::dp_sts_t dp_sts;
  ttss_pkg::result_t out_res;

  // Registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  // Sequencer: owns the input handshake and steps the poll walk
  ttss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // Datapath: queue, parity, event RAM and the result staging registers
  ttss_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .sts                (dp_sts),
    .in_cmd             (in_cmd),
    .in_time_point      (in_time_point),
    .in_data_offset     (in_data_offset),
    .in_data_length     (in_data_length),
    .in_now             (in_now),
    .in_comparator_busy (in_comparator_busy),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_res            (out_res),
    .out_last           (out_last)
  );

  // Split the result register onto the output ports
  assign out_status       = out_res.status;
  assign out_action       = out_res.action;
  assign out_mailbox_high = out_res.mb_high;
  assign out_mailbox_low  = out_res.mb_low;
  assign out_compare_time = out_res.cmp_time;

  // The queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dp_sts.entry_count <= ttss_pkg::CNT_W'(ttss_pkg::QUEUE_DEPTH))
    else $error("event queue fill exceeds depth");

  // Arming ends a poll walk, so an arm result is always the final one
  a_arm_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ttss_pkg::ACT_ARM_ON ||
                  out_action == ttss_pkg::ACT_ARM_OFF) |-> out_last)
    else $error("arm result not flagged last");

  // Error results are single, carry no action
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ttss_pkg::STS_OK |-> out_last &&
                                                  out_action == ttss_pkg::ACT_NONE)
    else $error("error result with action or not last");

  // One command at a time: no new transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

endmodule
